### src/segregated_free_list_allocator_defines.svh
// assertion macros for the allocator checker
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SFLA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// types and constants shared by the allocator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sfla_pkg;
    localparam int ARENA_BYTES_DEF  = 32768;
    localparam int GRANULE_DEF      = 8;
    localparam int NUM_CLASSES_DEF  = 16;
    localparam int REFILL_BATCH_DEF = 20;
    localparam logic [15:0] ARENA_LIMIT_RESET = 16'd32768;

    localparam logic [0:0] FUNC_ALLOC = 1'b0;
    localparam logic [0:0] FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;
    localparam logic [1:0] ST_NO_ARENA = 2'd3;

    typedef struct packed {
        logic [0:0]  func;
        logic [15:0] size;
        logic [14:0] address;
    } req_t;

    typedef struct packed {
        logic [14:0] block_address;
        logic [1:0]  status;
    } rsp_t;
endpackage
`default_nettype wire

### src/sfla_link_mem.sv
// ----------------------------------------------------------------------------
// sfla_link_mem
// synchronous link store, one write and one read port, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sfla_link_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 13
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### src/segregated_free_list_allocator.sv
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// small-block allocator with per-class lifo free lists in a link store
// ----------------------------------------------------------------------------
// usage
// - req channel (req_valid/req_ready/req) carries one allocate or free
//   transaction; rsp channel (rsp_valid/rsp_ready/rsp) returns one result
//   per transaction, in order
// - cfg channel (cfg_valid/cfg_ready/cfg_data) writes arena_limit; write it
//   only while no transaction is outstanding
// - free, zero size and too large: result registered at the accept edge,
//   the next transaction can follow at once while the receiver keeps up
// - allocate from a non-empty list: the accept starts the registered read
//   of the link store for the next head; S_POP registers the result
// - allocate with refill: S_REFIL, S_PREP when the pool is grown, then
//   S_CARVE with n up to the refill batch, one carved block pushed per
//   cycle, then S_POP; out of arena answers from S_REFIL or S_CARVE
// - one transaction at a time; the next is taken when the result register
//   is free or being taken in the same cycle
// - reset empties all class lists (valid bits in flip-flops), clears the
//   pool and sets arena_limit to its reset value; the link store itself
//   is not cleared since every entry is written before it is read
// - a stalled receiver holds the result in the output register and the
//   block then takes no new transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module segregated_free_list_allocator #(
    parameter int ARENA_BYTES  = sfla_pkg::ARENA_BYTES_DEF,
    parameter int GRANULE      = sfla_pkg::GRANULE_DEF,
    parameter int NUM_CLASSES  = sfla_pkg::NUM_CLASSES_DEF,
    parameter int REFILL_BATCH = sfla_pkg::REFILL_BATCH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire sfla_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output sfla_pkg::rsp_t       rsp,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data
);
    import sfla_pkg::*;

    localparam int DEPTH = ARENA_BYTES / GRANULE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int GSH   = $clog2(GRANULE);
    localparam int MAX_SMALL = NUM_CLASSES * GRANULE;
    localparam int PW    = 21;    // pool pointers, room for arena and growth
    localparam int BW    = (REFILL_BATCH > 1) ? $clog2(REFILL_BATCH + 1) : 1;
    localparam int HW    = AW + 1;    // valid bit plus granule index, as stored
    localparam logic [PW-1:0] ARENA_P = PW'(ARENA_BYTES);

    // state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_CARVE = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_POPW  = 3'd4;
    localparam logic [2:0] S_REFIL = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [HW-1:0] heads_reg [NUM_CLASSES];
    logic [PW-1:0] pool_start_reg, pool_end_reg;
    logic [15:0]   limit_reg;
    logic          out_v_reg, out_v_next;
    rsp_t          out_reg, out_next;
    logic [CW-1:0] cls_reg;
    logic [PW-1:0] bs_reg;
    logic [PW-1:0] carve_addr_reg;
    logic [BW-1:0] count_reg;

    // link store ports
    logic          lm_we, lm_re;
    logic [AW-1:0] lm_waddr, lm_raddr;
    logic [HW-1:0] lm_wdata, lm_rdata;

    sfla_link_mem #(.DEPTH(DEPTH), .AW(AW), .DW(HW)) u_link (
        .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
        .re(lm_re), .raddr(lm_raddr), .rdata(lm_rdata)
    );

    logic out_free;
    assign out_free  = !out_v_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;

    // decode of the incoming transaction
    logic          in_fire;
    logic [16:0]   sz_up;
    logic [CW-1:0] in_cls;
    logic [HW-1:0] in_head;
    logic [PW-1:0] free_g;
    assign in_fire = req_valid && req_ready;
    assign sz_up   = 17'(req.size) + 17'(GRANULE - 1);
    assign in_cls  = CW'((sz_up >> GSH) - 17'd1);
    assign in_head = heads_reg[in_cls];
    assign free_g  = PW'(req.address) >> GSH;

    // refill arithmetic, registered inputs only
    logic [PW-1:0] left, total, limit_eff, leftover_cls;
    logic [PW+1:0] grow_end;
    assign left      = pool_end_reg - pool_start_reg;
    assign total     = PW'(bs_reg * PW'(REFILL_BATCH));
    assign limit_eff = (PW'(limit_reg) < ARENA_P) ? PW'(limit_reg) : ARENA_P;
    assign grow_end  = (PW+2)'(pool_end_reg) + (PW+2)'({total, 1'b0});
    assign leftover_cls = (left >> GSH) - PW'(1);

    logic [BW-1:0] batch_n;
    always_comb
    begin
        // left < 2*total here and bs small: count by repeated compare
        batch_n = BW'(REFILL_BATCH);
        if (left < total)
        begin
            batch_n = '0;
            for (int i = 1; i <= REFILL_BATCH; i++)
            begin
                if (PW'(bs_reg * PW'(i)) <= left)
                begin
                    batch_n = BW'(i);
                end
            end
        end
    end

    logic arena_fail;
    assign arena_fail = (pool_end_reg > limit_eff) ||
                        (grow_end > (PW+2)'(limit_eff));

    // head update request
    logic          hw_en;
    logic [CW-1:0] hw_cls;
    logic [HW-1:0] hw_val;

    always_comb
    begin
        state_next = state_reg;
        out_v_next = out_v_reg && !rsp_ready;
        out_next   = out_reg;
        lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0;
        lm_re = 1'b0; lm_raddr = '0;
        hw_en = 1'b0; hw_cls = cls_reg; hw_val = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_next.block_address = '0;
                    out_next.status        = ST_OK;
                    if (req.size == 16'd0)
                    begin
                        out_next.status = ST_ZERO;
                        out_v_next      = 1'b1;
                    end
                    else if (17'(req.size) > 17'(MAX_SMALL))
                    begin
                        out_next.status = ST_TOO_BIG;
                        out_v_next      = 1'b1;
                    end
                    else if (req.func == FUNC_FREE)
                    begin
                        out_v_next = 1'b1;
                        if (free_g < PW'(DEPTH))
                        begin
                            lm_we = 1'b1; lm_waddr = AW'(free_g); lm_wdata = in_head;
                            hw_en = 1'b1; hw_cls = in_cls;
                            hw_val = {1'b1, AW'(free_g)};
                        end
                    end
                    else if (in_head[HW-1])
                    begin
                        out_next.block_address = 15'(PW'(in_head[AW-1:0]) << GSH);
                        lm_re = 1'b1; lm_raddr = in_head[AW-1:0];
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_REFIL;
                    end
                end
            end
            S_REFIL:
            begin
                if (left < bs_reg)
                begin
                    if (left >= PW'(GRANULE) && leftover_cls < PW'(NUM_CLASSES)
                        && (pool_start_reg >> GSH) < PW'(DEPTH))
                    begin
                        lm_we = 1'b1; lm_waddr = AW'(pool_start_reg >> GSH);
                        lm_wdata = heads_reg[CW'(leftover_cls)];
                        hw_en = 1'b1; hw_cls = CW'(leftover_cls);
                        hw_val = {1'b1, AW'(pool_start_reg >> GSH)};
                    end
                    if (arena_fail)
                    begin
                        out_next.status = ST_NO_ARENA;
                        out_v_next      = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
                else
                begin
                    state_next = S_CARVE;
                end
            end
            S_PREP:
            begin
                state_next = S_CARVE;
            end
            S_CARVE:
            begin
                if (count_reg != '0)
                begin
                    if ((carve_addr_reg >> GSH) < PW'(DEPTH))
                    begin
                        lm_we = 1'b1; lm_waddr = AW'(carve_addr_reg >> GSH);
                        lm_wdata = heads_reg[cls_reg];
                        hw_en = 1'b1;
                        hw_val = {1'b1, AW'(carve_addr_reg >> GSH)};
                    end
                end
                else if (heads_reg[cls_reg][HW-1])
                begin
                    out_next.block_address =
                        15'(PW'(heads_reg[cls_reg][AW-1:0]) << GSH);
                    lm_re = 1'b1; lm_raddr = heads_reg[cls_reg][AW-1:0];
                    state_next = S_POP;
                end
                else
                begin
                    out_next.status = ST_NO_ARENA;
                    out_v_next      = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_POP:
            begin
                hw_en = 1'b1; hw_val = lm_rdata;
                out_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_v_reg      <= 1'b0;
            out_reg        <= '0;
            cls_reg        <= '0;
            bs_reg         <= '0;
            carve_addr_reg <= '0;
            count_reg      <= '0;
            pool_start_reg <= '0;
            pool_end_reg   <= '0;
            limit_reg      <= ARENA_LIMIT_RESET;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
            out_reg   <= out_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (hw_en)
            begin
                heads_reg[hw_cls] <= hw_val;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cls_reg <= in_cls;
                        bs_reg  <= (PW'(in_cls) + PW'(1)) << GSH;
                    end
                end
                S_REFIL:
                begin
                    carve_addr_reg <= pool_start_reg;
                    count_reg      <= batch_n;
                    if (left < bs_reg)
                    begin
                        pool_start_reg <= pool_end_reg;
                        if (!arena_fail)
                        begin
                            pool_end_reg <= PW'(grow_end);
                        end
                    end
                end
                S_PREP:
                begin
                    carve_addr_reg <= pool_start_reg;
                    count_reg      <= BW'(REFILL_BATCH);
                end
                S_CARVE:
                begin
                    if (count_reg != '0)
                    begin
                        carve_addr_reg <= carve_addr_reg + bs_reg;
                        pool_start_reg <= pool_start_reg + bs_reg;
                        count_reg      <= count_reg - BW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### src/sfla_checker.sv
// ----------------------------------------------------------------------------
// sfla_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "segregated_free_list_allocator_defines.svh"
module sfla_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire sfla_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire sfla_pkg::rsp_t rsp
);
    import sfla_pkg::*;

    `SFLA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp), "result changed while stalled")
    `SFLA_ASSERT_IMPL(a_fail_zero_addr, clk, rst_n,
        rsp_valid && rsp.status != ST_OK, rsp.block_address == 15'd0,
        "failed result carries an address")
    // the next transaction only once the previous result is being taken
    `SFLA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready,
        !req_ready || (rsp_valid && rsp_ready),
        "second transaction taken while one is outstanding")
    `SFLA_ASSERT_IMPL(a_stall_blocks, clk, rst_n, rsp_valid && !rsp_ready,
        !req_ready, "transaction taken while result stalled")
endmodule
bind segregated_free_list_allocator sfla_checker u_sfla_checker (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
`default_nettype wire
